>>> src/lfp_pkg.sv
package lfp_pkg;

   localparam int TABLE_DEPTH_DEF       = 64;
   localparam int LONG_LAG_DEF          = 55;
   localparam int SHORT_LAG_DEF         = 24;
   localparam int MOD_BITS_DEF          = 48;
   localparam int WORDS_PER_REQUEST_DEF = 4;

   localparam int WORD_W = 64;

   // multiplier of the fill recurrence
   localparam logic [WORD_W-1:0] FILL_MULT = 64'd6364136223846793005;

   // request kinds carried on tuser
   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_GEN  = 1'b1;

endpackage

>>> src/lagged_fibonacci_prng_core.sv
// generate beat: the first word passes ST_GEN_RD, then each word ST_GEN_CALC and ST_GEN_OUT,
// which waits while rsp_tready is low; no new request is taken until the last word is accepted
// seed beat: with tlast each remaining entry is filled via ST_FILL_M0, M1, M2 and WR, using
// the shared 32x32 multiplier that forms the 64-bit fill product in three partial products
// reset: synchronous, active high; table entries read as zero until written, no clearing pass
module lagged_fibonacci_prng_core #(
   parameter int TABLE_DEPTH       = lfp_pkg::TABLE_DEPTH_DEF,
   parameter int LONG_LAG          = lfp_pkg::LONG_LAG_DEF,
   parameter int SHORT_LAG         = lfp_pkg::SHORT_LAG_DEF,
   parameter int MOD_BITS          = lfp_pkg::MOD_BITS_DEF,
   parameter int WORDS_PER_REQUEST = lfp_pkg::WORDS_PER_REQUEST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key_word
   input  logic        req_tuser,   // command
   input  logic        req_tlast,   // key_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // random_word
   output logic        rsp_tlast    // last_word
);

   localparam int WORD_W   = lfp_pkg::WORD_W;
   localparam int ADDR_W   = $clog2(TABLE_DEPTH);
   localparam int SUM_W    = ADDR_W + 1;
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int WCNT_W   = (WORDS_PER_REQUEST > 1) ? $clog2(WORDS_PER_REQUEST) : 1;
   localparam int LONG_OFF  = LONG_LAG % TABLE_DEPTH;
   localparam int SHORT_OFF = SHORT_LAG % TABLE_DEPTH;
   localparam logic [WORD_W-1:0] MOD_ADD  = 64'd1 << MOD_BITS;
   localparam logic [WORD_W-1:0] MOD_MASK = (64'd1 << MOD_BITS) - 64'd1;
   localparam logic [31:0] MULT_LO = lfp_pkg::FILL_MULT[31:0];
   localparam logic [31:0] MULT_HI = lfp_pkg::FILL_MULT[63:32];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_FILL_M0,
      ST_FILL_M1,
      ST_FILL_M2,
      ST_FILL_WR,
      ST_GEN_RD,
      ST_GEN_CALC,
      ST_GEN_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic              key_last_ff, key_last_in;
   logic              out_vld_ff, out_vld_in;
   logic              out_last_ff, out_last_in;
   logic [WORD_W-1:0] out_data_ff, out_data_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [WORD_W-1:0] acc_ff, acc_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   logic [WORD_W-1:0] rd_data_a;
   logic [WORD_W-1:0] rd_data_b;

   logic [SUM_W-1:0]  long_sum, long_wrap, short_sum, short_wrap;
   logic [31:0]       mul_a, mul_b;
   logic [WORD_W-1:0] prod;
   logic [WORD_W-1:0] diff, gen_word, fill_word;

   // lag taps relative to the current position
   always_comb begin
      long_sum   = {1'b0, pos_ff} + SUM_W'(LONG_OFF);
      long_wrap  = long_sum - SUM_W'(TABLE_DEPTH);
      short_sum  = {1'b0, pos_ff} + SUM_W'(SHORT_OFF);
      short_wrap = short_sum - SUM_W'(TABLE_DEPTH);
      rd_addr_a  = (long_sum >= SUM_W'(TABLE_DEPTH)) ? long_wrap[ADDR_W-1:0]
                                                     : long_sum[ADDR_W-1:0];
      rd_addr_b  = (short_sum >= SUM_W'(TABLE_DEPTH)) ? short_wrap[ADDR_W-1:0]
                                                      : short_sum[ADDR_W-1:0];
   end

   // shared 32x32 multiplier for the low 64 bits of prev * mult
   always_comb begin
      mul_a = (state_ff == ST_FILL_M1) ? prev_ff[63:32] : prev_ff[31:0];
      mul_b = (state_ff == ST_FILL_M2) ? MULT_HI : MULT_LO;
   end

   assign prod      = 64'(mul_a) * 64'(mul_b);
   assign fill_word = (acc_ff + 64'd1) & MOD_MASK;
   assign diff      = rd_data_a - rd_data_b;
   assign gen_word  = diff[WORD_W-1] ? diff + MOD_ADD : diff;

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      wcnt_in     = wcnt_ff;
      key_last_in = key_last_ff;
      out_vld_in  = out_vld_ff;
      out_last_in = out_last_ff;
      out_data_in = out_data_ff;
      prev_in     = prev_ff;
      acc_in      = acc_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = gen_word;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == lfp_pkg::CMD_GEN) begin
                  wcnt_in  = '0;
                  state_in = ST_GEN_RD;
               end else begin
                  prev_in     = req_tdata;
                  key_last_in = req_tlast;
                  if (req_tlast) begin
                     pos_in = '0;
                  end
                  state_in = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            if (cnt_ff < CNT_W'(TABLE_DEPTH)) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff[ADDR_W-1:0];
               wr_data = prev_ff;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            if (!key_last_ff) begin
               state_in = ST_IDLE;
            end else if (cnt_ff < CNT_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_FILL_M0;
            end else begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_FILL_M0: begin
            acc_in   = prod;
            state_in = ST_FILL_M1;
         end
         ST_FILL_M1: begin
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = ST_FILL_M2;
         end
         ST_FILL_M2: begin
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_data = fill_word;
            prev_in = fill_word;
            if (cnt_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_FILL_M0;
            end
         end
         ST_GEN_RD: begin
            state_in = ST_GEN_CALC;
         end
         ST_GEN_CALC: begin
            wr_en       = 1'b1;
            wr_addr     = pos_ff;
            wr_data     = gen_word;
            out_data_in = gen_word;
            out_last_in = (wcnt_ff == WCNT_W'(WORDS_PER_REQUEST - 1));
            out_vld_in  = 1'b1;
            pos_in      = (pos_ff == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : pos_ff + ADDR_W'(1);
            state_in    = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            // next word's taps are read while this beat waits
            if (rsp_tready) begin
               out_vld_in = 1'b0;
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  wcnt_in  = wcnt_ff + WCNT_W'(1);
                  state_in = ST_GEN_CALC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= '0;
         cnt_ff      <= '0;
         wcnt_ff     <= '0;
         key_last_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         wcnt_ff     <= wcnt_in;
         key_last_ff <= key_last_in;
         out_vld_ff  <= out_vld_in;
         out_last_ff <= out_last_in;
      end
      out_data_ff <= out_data_in;
      prev_ff     <= prev_in;
      acc_ff      <= acc_in;
   end

   lfp_table #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result beat is pending");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not ready after the final word of a request");

   a_pos_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == lfp_pkg::CMD_SEED) && req_tlast)
      |=> (pos_ff == '0))
      else $error("generation position not cleared by final key word");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (SUM_W'(wr_addr) < SUM_W'(TABLE_DEPTH)))
      else $error("table write beyond depth");

endmodule

>>> src/lfp_table.sv
module lfp_table #(
   parameter int DEPTH  = lfp_pkg::TABLE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [lfp_pkg::WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr_a,
   input  logic [ADDR_W-1:0]         rd_addr_b,
   output logic [lfp_pkg::WORD_W-1:0] rd_data_a,
   output logic [lfp_pkg::WORD_W-1:0] rd_data_b
);

   logic [lfp_pkg::WORD_W-1:0] table_mem [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [lfp_pkg::WORD_W-1:0] data_a_ff;
   logic [lfp_pkg::WORD_W-1:0] data_b_ff;
   logic                       vld_a_ff;
   logic                       vld_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      data_a_ff <= table_mem[rd_addr_a];
      data_b_ff <= table_mem[rd_addr_b];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_a_ff <= valid_ff[rd_addr_a];
         vld_b_ff <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = vld_a_ff ? data_a_ff : '0;
   assign rd_data_b = vld_b_ff ? data_b_ff : '0;

endmodule

>>> tb/lfp_checker.sv
`timescale 1ns / 1ps

module lfp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // key_word
   input  logic        req_tuser,   // command
   input  logic        req_tlast,   // key_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // random_word
   input  logic        rsp_tlast,   // last_word
   output int          fail_count,
   output int          words_pending
);

   localparam int DEPTH  = lfp_pkg::TABLE_DEPTH_DEF;
   localparam int LONG   = lfp_pkg::LONG_LAG_DEF;
   localparam int SHORT  = lfp_pkg::SHORT_LAG_DEF;
   localparam int WORDS  = lfp_pkg::WORDS_PER_REQUEST_DEF;
   localparam int WORD_W = lfp_pkg::WORD_W;
   localparam logic [WORD_W-1:0] MOD_MASK = (64'd1 << lfp_pkg::MOD_BITS_DEF) - 64'd1;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } lagged_word_type;

   logic [WORD_W-1:0] lag_words [DEPTH];
   int                gen_pos;
   int                key_count;
   lagged_word_type   expected_words [$];

   function automatic void load_key_word(input logic [WORD_W-1:0] word, input logic last);
      if (key_count < DEPTH) begin
         lag_words[key_count] = word;
         key_count++;
      end
      if (last) begin
         // remaining entries follow the fill recurrence
         for (int i = key_count; i < DEPTH; i++) begin
            if (i >= 1) begin
               lag_words[i] = (lfp_pkg::FILL_MULT * lag_words[i-1] + 64'd1) & MOD_MASK;
            end
         end
         key_count = 0;
         gen_pos   = 0;
      end
   endfunction

   function automatic logic [WORD_W-1:0] next_lagged_word();
      logic [WORD_W-1:0] diff;
      diff = lag_words[(gen_pos + LONG) % DEPTH] - lag_words[(gen_pos + SHORT) % DEPTH];
      if (diff[WORD_W-1]) begin
         diff = diff + (64'd1 << lfp_pkg::MOD_BITS_DEF);
      end
      lag_words[gen_pos] = diff;
      gen_pos = (gen_pos + 1) % DEPTH;
      return diff;
   endfunction

   always @(posedge clock) begin : monitor
      lagged_word_type want;
      if (reset) begin
         foreach (lag_words[i]) lag_words[i] = '0;
         gen_pos    = 0;
         key_count  = 0;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want.word) begin
                  $display("%0t: random_word mismatch, expected %h, actual %h",
                           $time, want.word, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_word mismatch, expected %b, actual %b",
                           $time, want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == lfp_pkg::CMD_SEED) begin
               load_key_word(req_tdata, req_tlast);
            end else begin
               for (int k = 0; k < WORDS; k++) begin
                  want.word = next_lagged_word();
                  want.last = (k == WORDS - 1);
                  expected_words.push_back(want);
               end
            end
         end
      end
      words_pending <= expected_words.size();
   end

endmodule

>>> tb/tb_lagged_fibonacci_prng_core.sv
`timescale 1ns / 1ps

module tb_lagged_fibonacci_prng_core;

   localparam int ITEM_TARGET = 410;
   localparam int CYCLE_LIMIT = 400000;
   localparam int END_CYCLES  = 400;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_PATTERN
   } ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // key_word
   logic        req_tuser = 1'b0; // command
   logic        req_tlast = 1'b0; // key_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // random_word
   logic        rsp_tlast;        // last_word

   int fail_count;
   int words_pending;

   int             cycle_count = 0;
   logic           hold_request = 1'b0;
   logic           hold_taken = 1'b0;
   int             hold_left = 0;
   ready_mode_type ready_mode = RX_ALWAYS;
   int             mode_left = 0;

   int burst_left = 0;
   int item_count = 0;
   int seq_kind;
   int seq_len;
   int gen_len;
   int overlong_done = 0;
   bit hold_done = 1'b0;
   bit drain_done = 1'b0;

   lagged_fibonacci_prng_core u_top (.*);

   lfp_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random modes, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 160);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= (cycle_count % 7 != 3) && (cycle_count % 5 != 0);
         endcase
      end
   end

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 64'h0;
         1:       return 64'hffff_ffff_ffff_ffff;
         2:       return 64'h8000_0000_0000_0000;
         3:       return 64'h7fff_ffff_ffff_ffff;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_item(input logic cmd, input logic [63:0] word, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= cmd;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      item_count++;
   endtask

   task automatic send_generate();
      send_item(lfp_pkg::CMD_GEN, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_key(input int len);
      for (int i = 0; i < len; i++) begin
         send_item(lfp_pkg::CMD_SEED, pick_word(), i == len - 1);
      end
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (words_pending != 0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero table, one-word keys, extremes, partial key
      send_generate();
      send_item(lfp_pkg::CMD_SEED, 64'hffff_ffff_ffff_ffff, 1'b1);
      send_generate();
      send_generate();
      send_item(lfp_pkg::CMD_SEED, 64'h0, 1'b0);
      send_item(lfp_pkg::CMD_SEED, 64'h8000_0000_0000_0000, 1'b0);
      send_item(lfp_pkg::CMD_SEED, 64'h7fff_ffff_ffff_ffff, 1'b1);
      send_generate();
      send_generate();
      send_item(lfp_pkg::CMD_SEED, 64'h0000_ffff_ffff_ffff, 1'b0);
      send_generate();
      send_item(lfp_pkg::CMD_SEED, 64'h5555_5555_5555_5555, 1'b1);
      send_generate();
      send_generate();
      send_item(lfp_pkg::CMD_SEED, 64'h1, 1'b1);
      send_generate();
      send_generate();
      send_generate();
      send_item(lfp_pkg::CMD_GEN, 64'hffff_ffff_ffff_ffff, 1'b1);

      while (item_count < ITEM_TARGET) begin
         if (!hold_done && item_count > 150) begin
            // receiver holds off while generates keep coming
            hold_done = 1'b1;
            hold_request <= 1'b1;
            burst_left = 12;
            repeat (12) send_generate();
         end
         if (!drain_done && item_count > 260) begin
            drain_done = 1'b1;
            req_tvalid <= 1'b0;
            wait_for_results();
         end
         seq_kind = $urandom_range(0, 9);
         if (seq_kind <= 4) begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 6);
            send_key(seq_len);
            gen_len = $urandom_range(1, 5);
            repeat (gen_len) send_generate();
         end else if (seq_kind <= 6) begin
            gen_len = $urandom_range(1, 4);
            repeat (gen_len) send_generate();
         end else if (seq_kind == 7) begin
            seq_len = $urandom_range(1, 3);
            for (int i = 0; i < seq_len; i++) send_item(lfp_pkg::CMD_SEED, pick_word(), 1'b0);
            gen_len = $urandom_range(1, 2);
            repeat (gen_len) send_generate();
         end else if (seq_kind == 8) begin
            seq_len = $urandom_range(1, 4);
            for (int i = 0; i < seq_len; i++) begin
               send_item(1'($urandom_range(0, 1)), pick_word(), 1'($urandom_range(0, 1)));
            end
         end else if (overlong_done < 2) begin
            // key longer than the table, last beat dropped
            overlong_done++;
            send_key($urandom_range(65, 67));
            repeat (2) send_generate();
         end else begin
            send_generate();
         end
      end

      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
